/* rtl/bgf_pkg.sv */
package bgf_pkg;

  localparam int MAX_BYTES_DEF = 256;
  localparam int SIZE_W        = 9;
  localparam int SIZE_MAX      = 2 ** SIZE_W - 1;
  localparam int CNT_W         = 6;
  localparam int DATA_W        = 32;
  localparam int LVL_W         = 11;
  localparam int BUF_W         = 40;
  localparam int NB_W          = 3;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 9'd256;
  localparam logic [CNT_W-1:0]  CNT_MAX    = 6'd32;

  localparam logic FUNC_PUSH = 1'b0;
  localparam logic FUNC_POP  = 1'b1;

  typedef struct packed {
    logic              func;
    logic [CNT_W-1:0]  bit_count;
    logic [DATA_W-1:0] data_in;
  } in_t;

  typedef struct packed {
    logic              ok;
    logic [DATA_W-1:0] data_out;
    logic [LVL_W-1:0]  available_bits;
    logic [LVL_W-1:0]  free_bits;
  } out_t;

  typedef struct packed {
    logic              func;
    logic [2:0]        sh;
    logic [CNT_W-1:0]  cnt;
    logic [NB_W-1:0]   nbytes;
    logic [DATA_W-1:0] data;
  } job_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] pop_data;
  } stat_t;

  function automatic logic [DATA_W-1:0] cnt_mask(input logic [CNT_W-1:0] c);
    logic [DATA_W:0] m;
    m = ({{DATA_W{1'b0}}, 1'b1} << c) - {{DATA_W{1'b0}}, 1'b1};
    return m[DATA_W-1:0];
  endfunction

endpackage

/* rtl/bgf_ram.sv */
module bgf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/bgf_seq.sv */
module bgf_seq #(
  parameter int DEPTH = bgf_pkg::MAX_BYTES_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  bgf_pkg::job_t            job,
  input  logic [$clog2(DEPTH)-1:0] start_addr,
  input  logic [$clog2(DEPTH)-1:0] last_addr,
  output bgf_pkg::stat_t           stat
);

  localparam int ADDR_W = $clog2(DEPTH);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PRD  = 3'd1;
  localparam logic [2:0] S_PWR  = 3'd2;
  localparam logic [2:0] S_RD   = 3'd3;
  localparam logic [2:0] S_RL   = 3'd4;
  localparam logic [2:0] S_ALN  = 3'd5;

  logic [2:0]                     state_r;
  logic                           done_r;
  logic                           rv_r;
  logic [bgf_pkg::NB_W-1:0]       nleft_r;
  logic [ADDR_W-1:0]              addr_r;
  logic [bgf_pkg::NB_W-1:0]       k_r;
  logic [bgf_pkg::BUF_W-1:0]      buf_r;
  logic [2:0]                     sh_r;
  logic [bgf_pkg::CNT_W-1:0]      cnt_r;
  logic                           merge_r;
  logic [bgf_pkg::DATA_W-1:0]     pop_r;

  logic                           ram_we;
  logic                           ram_re;
  logic [7:0]                     ram_wdata;
  logic [7:0]                     ram_rdata;
  logic [ADDR_W-1:0]              addr_inc;
  logic [7:0]                     keep_mask;
  logic [bgf_pkg::BUF_W-1:0]      push_bits;
  logic [bgf_pkg::BUF_W-1:0]      aligned;

  assign ram_we    = (state_r == S_PWR);
  assign ram_re    = (state_r == S_PRD) || (state_r == S_RD);
  assign keep_mask = ~(8'hFF << sh_r);
  assign ram_wdata = merge_r ? ((ram_rdata & keep_mask) | buf_r[7:0]) : buf_r[7:0];
  assign addr_inc  = (addr_r == last_addr) ? '0 : addr_r + ADDR_W'(1);
  assign push_bits = {8'b0, job.data & bgf_pkg::cnt_mask(job.cnt)} << job.sh;
  assign aligned   = buf_r >> sh_r;

  bgf_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (addr_r),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (addr_r),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      done_r  <= 1'b0;
      rv_r    <= 1'b0;
      nleft_r <= '0;
    end else begin
      done_r <= 1'b0;
      rv_r   <= ram_re;
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            nleft_r <= job.nbytes;
            if (job.func == bgf_pkg::FUNC_POP) begin
              state_r <= S_RD;
            end else if (job.sh != 3'd0) begin
              state_r <= S_PRD;
            end else begin
              state_r <= S_PWR;
            end
          end
        end
        S_PRD: begin
          state_r <= S_PWR;
        end
        S_PWR: begin
          nleft_r <= nleft_r - bgf_pkg::NB_W'(1);
          if (nleft_r == bgf_pkg::NB_W'(1)) begin
            state_r <= S_IDLE;
            done_r  <= 1'b1;
          end
        end
        S_RD: begin
          nleft_r <= nleft_r - bgf_pkg::NB_W'(1);
          if (nleft_r == bgf_pkg::NB_W'(1)) begin
            state_r <= S_RL;
          end
        end
        S_RL: begin
          state_r <= S_ALN;
        end
        S_ALN: begin
          state_r <= S_IDLE;
          done_r  <= 1'b1;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rv_r && ((state_r == S_RD) || (state_r == S_RL))) begin
      buf_r[{k_r, 3'b000} +: 8] <= ram_rdata;
      k_r                       <= k_r + bgf_pkg::NB_W'(1);
    end
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          addr_r  <= start_addr;
          k_r     <= '0;
          sh_r    <= job.sh;
          cnt_r   <= job.cnt;
          merge_r <= (job.sh != 3'd0);
          buf_r   <= (job.func == bgf_pkg::FUNC_POP) ? '0 : push_bits;
        end
      end
      S_PWR: begin
        buf_r   <= buf_r >> 8;
        merge_r <= 1'b0;
        addr_r  <= addr_inc;
      end
      S_RD: begin
        addr_r <= addr_inc;
      end
      S_ALN: begin
        pop_r <= aligned[bgf_pkg::DATA_W-1:0] & bgf_pkg::cnt_mask(cnt_r);
      end
      default: begin
      end
    endcase
  end

  assign stat.done     = done_r;
  assign stat.pop_data = pop_r;

endmodule

/* rtl/bit_granular_fifo_unit.sv */
// bit-granular ring fifo held in a byte ram, lsb first
// request: start with in_req (func push/pop, bit_count, data_in), taken at a
// rising edge where start is high and busy is low
// result: out_res valid for exactly one cycle while out_strobe is high; the
// receiver cannot stall, so nothing holds the result back
// configuration: cfg_we writes cfg_data as the ring size in bytes and empties
// the fifo; write it only while busy is low and no result is pending
// latency: a refused or zero-count request gives its result 1 cycle after
// acceptance, busy stays low
// a push touching n bytes (1..5) takes n+2 cycles to its result, plus one
// cycle to read the first byte when the write position is mid-byte
// a pop touching n bytes takes n+4 cycles to its result
// rate: one byte ram access per cycle sets it, busy drops the cycle the
// result appears, so the next request follows after n+2 to n+4 cycles
// reset: positions cleared, size back to 256 bytes, ram contents untouched
module bit_granular_fifo_unit #(
  parameter int MAX_BYTES = bgf_pkg::MAX_BYTES_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  bgf_pkg::in_t               in_req,
  output logic                       out_strobe,
  output bgf_pkg::out_t              out_res,
  input  logic                       cfg_we,
  input  logic [bgf_pkg::SIZE_W-1:0] cfg_data
);

  localparam int EFF_MAX = (MAX_BYTES < bgf_pkg::SIZE_MAX) ? MAX_BYTES : bgf_pkg::SIZE_MAX;
  localparam int POS_W   = $clog2(EFF_MAX * 8);
  localparam int CAP_W   = POS_W + 1;
  localparam int EB_W    = CAP_W - 3;
  localparam int ADDR_W  = POS_W - 3;

  localparam logic T_IDLE = 1'b0;
  localparam logic T_RUN  = 1'b1;

  function automatic logic [CAP_W-1:0] size_to_cap(input logic [bgf_pkg::SIZE_W-1:0] s);
    logic [EB_W-1:0] eb;
    if (s < bgf_pkg::SIZE_W'(2)) begin
      eb = EB_W'(2);
    end else if (32'(s) > 32'(EFF_MAX)) begin
      eb = EB_W'(EFF_MAX);
    end else begin
      eb = EB_W'(s);
    end
    return {eb, 3'b000};
  endfunction

  logic                       state_r;
  logic [CAP_W-1:0]           cap_r;
  logic [POS_W-1:0]           rd_pos_r;
  logic [POS_W-1:0]           wr_pos_r;
  logic                       func_r;
  logic                       out_strobe_r;
  bgf_pkg::out_t              out_res_r;

  logic [CAP_W-1:0]           held_w;
  logic [CAP_W-1:0]           used_w;
  logic [POS_W-1:0]           held;
  logic [POS_W-1:0]           room;
  logic [bgf_pkg::CNT_W-1:0]  cnt_sat;
  logic                       is_pop;
  logic                       req_ok;
  logic [POS_W-1:0]           cur_pos;
  logic [31:0]                pos_sum;
  logic [POS_W-1:0]           new_pos;
  logic [5:0]                 nb_sum;
  logic                       accept;
  logic                       go;
  bgf_pkg::job_t              job;
  logic [ADDR_W-1:0]          start_addr;
  logic [ADDR_W-1:0]          last_addr;
  bgf_pkg::stat_t             stat;

  always_comb begin
    if (wr_pos_r >= rd_pos_r) begin
      held_w = CAP_W'(wr_pos_r) - CAP_W'(rd_pos_r);
    end else begin
      held_w = cap_r - CAP_W'(rd_pos_r) + CAP_W'(wr_pos_r);
    end
    held   = POS_W'(held_w);
    used_w = held_w + CAP_W'(8);
    room   = (used_w > cap_r) ? '0 : POS_W'(cap_r - used_w);
  end

  assign cnt_sat = (in_req.bit_count > bgf_pkg::CNT_MAX) ? bgf_pkg::CNT_MAX : in_req.bit_count;
  assign is_pop  = (in_req.func == bgf_pkg::FUNC_POP);
  assign req_ok  = is_pop ? (32'(held) >= 32'(cnt_sat)) : (32'(room) >= 32'(cnt_sat));
  assign cur_pos = is_pop ? rd_pos_r : wr_pos_r;
  assign pos_sum = 32'(cur_pos) + 32'(cnt_sat);
  assign new_pos = (pos_sum >= 32'(cap_r)) ? POS_W'(pos_sum - 32'(cap_r)) : POS_W'(pos_sum);
  assign nb_sum  = 6'(cur_pos[2:0]) + 6'(cnt_sat) + 6'd7;
  assign accept  = start && (state_r == T_IDLE);
  assign go      = accept && req_ok && (cnt_sat != '0);

  assign job.func    = in_req.func;
  assign job.sh      = cur_pos[2:0];
  assign job.cnt     = cnt_sat;
  assign job.nbytes  = nb_sum[5:3];
  assign job.data    = in_req.data_in;
  assign start_addr  = cur_pos[POS_W-1:3];
  assign last_addr   = ADDR_W'(cap_r[CAP_W-1:3] - EB_W'(1));

  bgf_seq #(
    .DEPTH (EFF_MAX)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (go),
    .job        (job),
    .start_addr (start_addr),
    .last_addr  (last_addr),
    .stat       (stat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= T_IDLE;
      cap_r        <= size_to_cap(bgf_pkg::SIZE_RESET);
      rd_pos_r     <= '0;
      wr_pos_r     <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= 1'b0;
      if (cfg_we) begin
        cap_r    <= size_to_cap(cfg_data);
        rd_pos_r <= '0;
        wr_pos_r <= '0;
      end else if (accept) begin
        if (go) begin
          state_r <= T_RUN;
          if (is_pop) begin
            rd_pos_r <= new_pos;
          end else begin
            wr_pos_r <= new_pos;
          end
        end else begin
          out_strobe_r <= 1'b1;
        end
      end
      if ((state_r == T_RUN) && stat.done) begin
        state_r      <= T_IDLE;
        out_strobe_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      func_r <= in_req.func;
      if (!go) begin
        out_res_r.ok             <= req_ok;
        out_res_r.data_out       <= '0;
        out_res_r.available_bits <= bgf_pkg::LVL_W'(held);
        out_res_r.free_bits      <= bgf_pkg::LVL_W'(room);
      end
    end
    if ((state_r == T_RUN) && stat.done) begin
      out_res_r.ok             <= 1'b1;
      out_res_r.data_out       <= (func_r == bgf_pkg::FUNC_POP) ? stat.pop_data : '0;
      out_res_r.available_bits <= bgf_pkg::LVL_W'(held);
      out_res_r.free_bits      <= bgf_pkg::LVL_W'(room);
    end
  end

  assign busy       = (state_r != T_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_res    = out_res_r;

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r |-> (state_r == T_IDLE))
    else $error("result strobe while a request is still running");

  a_done_run: assert property (@(posedge clk) disable iff (!rst_n)
    stat.done |-> (state_r == T_RUN))
    else $error("sequencer done without a running request");

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    (CAP_W'(rd_pos_r) < cap_r) && (CAP_W'(wr_pos_r) < cap_r))
    else $error("bit position outside ring capacity");

  a_go_busy: assert property (@(posedge clk) disable iff (!rst_n)
    go |=> busy && !out_strobe_r)
    else $error("started request not marked busy");

endmodule

/* sim/bit_granular_fifo_unit_tb.sv */
module bit_granular_fifo_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RING_MAX_BITS = bgf_pkg::MAX_BYTES_DEF * 8;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int NUM_PHASES    = 8;
  localparam int NUM_ROWS      = 24;

  typedef struct packed {
    logic                       is_cfg;
    logic [bgf_pkg::SIZE_W-1:0] size;
    bgf_pkg::in_t               req;
    logic                       typed;
    bgf_pkg::out_t              want;
  } step_t;

  logic                       clk;
  logic                       rst_n;
  logic                       start;
  logic                       busy;
  bgf_pkg::in_t               in_req;
  logic                       out_strobe;
  bgf_pkg::out_t              out_res;
  logic                       cfg_we;
  logic [bgf_pkg::SIZE_W-1:0] cfg_data;

  // predictor state
  logic [bgf_pkg::SIZE_W-1:0] size_reg;
  int unsigned                rd_pos;
  int unsigned                wr_pos;
  bit                         bit_store [0:RING_MAX_BITS-1];

  bgf_pkg::out_t pending_results [$];
  bgf_pkg::out_t want_res;
  int            mismatches;
  int            cycles;

  step_t dir_table [NUM_ROWS];

  bit_granular_fifo_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_req     (in_req),
    .out_strobe (out_strobe),
    .out_res    (out_res),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int unsigned ring_bits();
    int unsigned s;
    s = size_reg;
    if (s < 2) s = 2;
    if (s > bgf_pkg::MAX_BYTES_DEF) s = bgf_pkg::MAX_BYTES_DEF;
    return s * 8;
  endfunction

  function automatic int unsigned fill_bits(input int unsigned cap);
    if (wr_pos >= rd_pos) return wr_pos - rd_pos;
    return cap - rd_pos + wr_pos;
  endfunction

  function automatic int unsigned space_bits(input int unsigned cap);
    int unsigned used;
    used = fill_bits(cap) + 8;
    return (used > cap) ? 0 : cap - used;
  endfunction

  function automatic bgf_pkg::out_t predict_fifo(input bgf_pkg::in_t r);
    bgf_pkg::out_t res;
    int unsigned   cap;
    int unsigned   n;
    cap = ring_bits();
    n   = (r.bit_count > bgf_pkg::CNT_MAX) ? bgf_pkg::CNT_MAX : r.bit_count;
    res = '0;
    if (r.func == bgf_pkg::FUNC_PUSH) begin
      if (space_bits(cap) >= n) begin
        res.ok = 1'b1;
        for (int i = 0; i < n; i++) begin
          bit_store[wr_pos] = r.data_in[i];
          wr_pos = (wr_pos + 1 >= cap) ? 0 : wr_pos + 1;
        end
      end
    end else if (fill_bits(cap) >= n) begin
      res.ok = 1'b1;
      for (int i = 0; i < n; i++) begin
        res.data_out[i] = bit_store[rd_pos];
        rd_pos = (rd_pos + 1 >= cap) ? 0 : rd_pos + 1;
      end
    end
    res.available_bits = bgf_pkg::LVL_W'(fill_bits(cap));
    res.free_bits      = bgf_pkg::LVL_W'(space_bits(cap));
    return res;
  endfunction

  function automatic step_t op_row(input logic f, input int cnt, input logic [31:0] d);
    step_t s;
    s = '0;
    s.req.func      = f;
    s.req.bit_count = bgf_pkg::CNT_W'(cnt);
    s.req.data_in   = d;
    return s;
  endfunction

  function automatic step_t chk_row(input logic f, input int cnt, input logic [31:0] d,
                                    input logic ok, input logic [31:0] dout,
                                    input int avail, input int room);
    step_t s;
    s = op_row(f, cnt, d);
    s.typed = 1'b1;
    s.want  = '{ok: ok, data_out: dout, available_bits: bgf_pkg::LVL_W'(avail),
                free_bits: bgf_pkg::LVL_W'(room)};
    return s;
  endfunction

  function automatic step_t cfg_row(input int size);
    step_t s;
    s = '0;
    s.is_cfg = 1'b1;
    s.size   = bgf_pkg::SIZE_W'(size);
    return s;
  endfunction

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // called at a falling edge, returns at a falling edge with start low
  task automatic send_req(input bgf_pkg::in_t r, input int gap, input bit typed,
                          input bgf_pkg::out_t typed_res);
    bgf_pkg::out_t p;
    repeat (gap) @(negedge clk);
    start  = 1'b1;
    in_req = r;
    do @(posedge clk); while (busy);
    p = predict_fifo(r);
    pending_results.push_back(typed ? typed_res : p);
    @(negedge clk);
    start = 1'b0;
  endtask

  task automatic drain();
    while (pending_results.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_ring_size(input logic [bgf_pkg::SIZE_W-1:0] v);
    drain();
    repeat (4) @(negedge clk);
    cfg_we   = 1'b1;
    cfg_data = v;
    @(negedge clk);
    cfg_we   = 1'b0;
    size_reg = v;
    rd_pos   = 0;
    wr_pos   = 0;
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t timeout with %0d results outstanding", $time, pending_results.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t unexpected result: got %p", $time, out_res);
      end else begin
        want_res = pending_results.pop_front();
        if (out_res.ok !== want_res.ok) begin
          mismatches++;
          $display("%0t ok: expected %0b got %0b", $time, want_res.ok, out_res.ok);
        end
        if (out_res.data_out !== want_res.data_out) begin
          mismatches++;
          $display("%0t data_out: expected %h got %h", $time, want_res.data_out,
                   out_res.data_out);
        end
        if (out_res.available_bits !== want_res.available_bits) begin
          mismatches++;
          $display("%0t available_bits: expected %0d got %0d", $time,
                   want_res.available_bits, out_res.available_bits);
        end
        if (out_res.free_bits !== want_res.free_bits) begin
          mismatches++;
          $display("%0t free_bits: expected %0d got %0d", $time, want_res.free_bits,
                   out_res.free_bits);
        end
      end
    end
  end

  initial begin
    logic [bgf_pkg::SIZE_W-1:0] ring_sizes [NUM_PHASES];
    bgf_pkg::in_t               r;
    int unsigned                cap;
    int unsigned                held;
    int unsigned                room;
    int                         n_items;
    int                         push_pct;
    int                         cnt;
    int                         gap;

    start      = 1'b0;
    in_req     = '0;
    cfg_we     = 1'b0;
    cfg_data   = '0;
    rst_n      = 1'b0;
    mismatches = 0;
    cycles     = 0;
    size_reg   = bgf_pkg::SIZE_RESET;
    rd_pos     = 0;
    wr_pos     = 0;
    foreach (bit_store[i]) bit_store[i] = 1'b0;

    dir_table = '{
      chk_row(bgf_pkg::FUNC_PUSH, 0, 32'hFFFF_FFFF, 1'b1, 32'h0, 0, 2040),
      chk_row(bgf_pkg::FUNC_POP, 1, 32'h0, 1'b0, 32'h0, 0, 2040),
      chk_row(bgf_pkg::FUNC_PUSH, 32, 32'hFFFF_FFFF, 1'b1, 32'h0, 32, 2008),
      chk_row(bgf_pkg::FUNC_POP, 32, 32'h0, 1'b1, 32'hFFFF_FFFF, 0, 2040),
      chk_row(bgf_pkg::FUNC_PUSH, 63, 32'hA5A5_A5A5, 1'b1, 32'h0, 32, 2008),
      chk_row(bgf_pkg::FUNC_POP, 40, 32'h0, 1'b1, 32'hA5A5_A5A5, 0, 2040),
      op_row(bgf_pkg::FUNC_PUSH, 3, 32'h0000_0005),
      op_row(bgf_pkg::FUNC_PUSH, 32, 32'h1234_5678),
      op_row(bgf_pkg::FUNC_POP, 0, 32'h0),
      op_row(bgf_pkg::FUNC_POP, 7, 32'h0),
      op_row(bgf_pkg::FUNC_POP, 28, 32'h0),
      op_row(bgf_pkg::FUNC_PUSH, 33, 32'hDEAD_BEEF),
      op_row(bgf_pkg::FUNC_POP, 33, 32'h0),
      cfg_row(0),
      chk_row(bgf_pkg::FUNC_PUSH, 9, 32'h0000_01FF, 1'b0, 32'h0, 0, 8),
      chk_row(bgf_pkg::FUNC_PUSH, 8, 32'h0000_00FF, 1'b1, 32'h0, 8, 0),
      chk_row(bgf_pkg::FUNC_PUSH, 1, 32'h0000_0001, 1'b0, 32'h0, 8, 0),
      chk_row(bgf_pkg::FUNC_POP, 9, 32'h0, 1'b0, 32'h0, 8, 0),
      op_row(bgf_pkg::FUNC_POP, 5, 32'h0),
      op_row(bgf_pkg::FUNC_PUSH, 5, 32'h0000_001F),
      op_row(bgf_pkg::FUNC_POP, 8, 32'h0),
      cfg_row(511),
      chk_row(bgf_pkg::FUNC_PUSH, 32, 32'h0, 1'b1, 32'h0, 32, 2008),
      chk_row(bgf_pkg::FUNC_POP, 32, 32'h0, 1'b1, 32'h0, 0, 2040)
    };

    ring_sizes = '{9'd256, 9'd2, 9'd3, 9'd257, 9'd1, 9'd40, 9'd511, 9'd0};
    ring_sizes[5] = bgf_pkg::SIZE_W'($urandom_range(4, 255));

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed
    foreach (dir_table[i]) begin
      if (dir_table[i].is_cfg) set_ring_size(dir_table[i].size);
      else send_req(dir_table[i].req, pick_gap(), dir_table[i].typed, dir_table[i].want);
    end

    // random phases, each at its own ring size
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      set_ring_size(ring_sizes[ph]);
      n_items = (ph == 0) ? 160 : 35;
      for (int k = 0; k < n_items; k++) begin
        cap  = ring_bits();
        held = fill_bits(cap);
        room = space_bits(cap);
        push_pct = (k < n_items * 3 / 4) ? 90 : 15;
        r.func = ($urandom_range(0, 99) < push_pct) ? bgf_pkg::FUNC_PUSH : bgf_pkg::FUNC_POP;
        if ($urandom_range(0, 99) < 12) cnt = $urandom_range(0, 63);
        else if (r.func == bgf_pkg::FUNC_PUSH) cnt = $urandom_range(0, (room < 32) ? room : 32);
        else cnt = $urandom_range(0, (held < 32) ? held : 32);
        r.bit_count = bgf_pkg::CNT_W'(cnt);
        case ($urandom_range(0, 9))
          0: r.data_in = '0;
          1: r.data_in = '1;
          default: r.data_in = $urandom;
        endcase
        gap = (ph == 0 && k < 40) ? 0 : pick_gap();
        if ($urandom_range(0, 49) == 0) drain();
        send_req(r, gap, 1'b0, '0);
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
